@@ rtl/core/pidfd_pkg.sv @@
package pidfd_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned WIDE_W = 33;
    localparam int unsigned PROD_W = 66;
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic signed [WORD_W-1:0] ONE_Q = 32'sh0001_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_RATIO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_BIAS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_MODE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CEILING = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_FLOOR   = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P_ERR,
        ST_KIKP,
        ST_KPKD,
        ST_KIH,
        ST_KIH_DONE,
        ST_IK_MUL,
        ST_IK,
        ST_GAMMA_WAIT,
        ST_GH,
        ST_T1_DIV,
        ST_T1_WAIT,
        ST_T2_DIV,
        ST_T2_WAIT,
        ST_SUM
    } t_state;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        logic signed [WORD_W-1:0] r;
        hi = 66'sh0_7FFF_FFFF;
        lo = -66'sh0_8000_0000;
        if (v > hi) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/pidfd_div.sv @@
module pidfd_div
    import pidfd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [PROD_W-1:0] i_dividend,
    input  logic signed [WIDE_W-1:0] i_divisor,
    output logic                     o_done,
    output logic signed [WORD_W-1:0] o_quotient
);

    localparam logic [6:0] STEPS = 7'(PROD_W);

    logic               r_busy;
    logic               r_done;
    logic [6:0]         r_cnt;
    logic               r_neg;
    logic [PROD_W-1:0]  r_quo;
    logic [WIDE_W-1:0]  r_dvs;
    logic [WIDE_W:0]    r_rem;
    logic [WIDE_W:0]    rem_sh;
    logic               ge;

    assign rem_sh = {r_rem[WIDE_W-1:0], r_quo[PROD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Restoring division on magnitudes, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[PROD_W-1] ^ i_divisor[WIDE_W-1];
            r_quo <= i_dividend[PROD_W-1] ? PROD_W'(-i_dividend) : PROD_W'(i_dividend);
            r_dvs <= i_divisor[WIDE_W-1] ? WIDE_W'(-i_divisor) : WIDE_W'(i_divisor);
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
            r_quo <= {r_quo[PROD_W-2:0], ge};
        end
    end

    always_comb begin
        if (!r_neg) begin
            if (r_quo > PROD_W'(32'h7FFF_FFFF)) begin
                o_quotient = 32'sh7FFF_FFFF;
            end else begin
                o_quotient = r_quo[WORD_W-1:0];
            end
        end else begin
            if (r_quo > PROD_W'(33'h1_0000_0000 >> 1)) begin
                o_quotient = 32'sh8000_0000;
            end else begin
                o_quotient = -r_quo[WORD_W-1:0];
            end
        end
    end

    assign o_done = r_done;

endmodule

@@ rtl/core/pid_filtered_derivative_antiwindup.sv @@
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_setpoint, i_measured
// result    out        o_out_valid / i_out_stall  o_drive
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
// A transaction runs the multiply and control states plus three passes of the shared
// bit-serial divider, each pass producing 66 quotient bits. When gamma plus the tick
// period is zero the last two divider passes are skipped.
// The block stalls its input from acceptance until the result is registered;
// a finished result waits in the output register while the next transaction enters.
// Synchronous active-low reset clears the controller state and sets the configuration to its defaults.
module pid_filtered_derivative_antiwindup
    import pidfd_pkg::*;
#(
    parameter int PERIOD_MS    = 100,
    parameter int OUT_MAX_COLD = 0,
    parameter int OUT_MIN_COLD = -255,
    parameter int OUT_MAX_HOT  = 255,
    parameter int OUT_MIN_HOT  = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [WORD_W-1:0]           i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [WORD_W-1:0]    i_setpoint,
    input  logic signed [WORD_W-1:0]    i_measured,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [7:0]                  o_drive
);

    localparam logic signed [WIDE_W-1:0] H_Q =
        WIDE_W'((PERIOD_MS * 65536 + 500) / 1000);
    localparam logic signed [WORD_W-1:0] OMAX_HOT  = WORD_W'(OUT_MAX_HOT * 65536);
    localparam logic signed [WORD_W-1:0] OMIN_HOT  = WORD_W'(OUT_MIN_HOT * 65536);
    localparam logic signed [WORD_W-1:0] OMAX_COLD = WORD_W'(OUT_MAX_COLD * 65536);
    localparam logic signed [WORD_W-1:0] OMIN_COLD = WORD_W'(OUT_MIN_COLD * 65536);

    logic signed [WORD_W-1:0] r_gain_p, r_gain_i, r_gain_d, r_filter_ratio;
    logic signed [WORD_W-1:0] r_drive_bias, r_temp_ceiling, r_temp_floor;
    logic                     r_heat_mode;

    logic signed [WORD_W-1:0] r_last_ms, r_last_sp, r_integ, r_deriv;
    logic signed [WORD_W-1:0] r_sp, r_ms;
    logic signed [WORD_W-1:0] r_pk, r_kih, r_kpkd, r_ik, r_gamma, r_t1, r_dk;
    logic signed [WIDE_W-1:0] r_gh;
    logic signed [PROD_W-1:0] r_prod;

    logic                     r_out_valid;
    logic [7:0]               r_drive;

    t_state r_state, n_state;

    logic                     mul_en;
    logic signed [WIDE_W-1:0] mul_a, mul_b;
    logic                     div_start;
    logic signed [PROD_W-1:0] div_dividend;
    logic signed [WIDE_W-1:0] div_divisor;
    logic                     div_done;
    logic signed [WORD_W-1:0] div_q;

    logic signed [WIDE_W-1:0] err, perr, dm, gh_next;
    logic signed [WORD_W-1:0] prod_q;
    logic signed [WORD_W-1:0] ik_next, dk_next;
    logic signed [WORD_W-1:0] omax, omin, s_sum, s_clamp, integ_next;
    logic signed [WIDE_W-1:0] s_final;
    logic [7:0]               drive_next;
    logic                     in_take, out_free;

    assign err  = WIDE_W'(r_sp) - WIDE_W'(r_ms);
    assign perr = WIDE_W'(r_last_sp) - WIDE_W'(r_last_ms);
    assign dm   = WIDE_W'(r_ms) - WIDE_W'(r_last_ms);
    assign prod_q  = sat32(r_prod >>> 16);
    assign ik_next = sat32(PROD_W'(r_integ) + PROD_W'(prod_q));
    assign gh_next = WIDE_W'(div_q) + H_Q;
    assign dk_next = sat32(PROD_W'(r_t1) - PROD_W'(div_q));

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p       <= '0;
            r_gain_i       <= '0;
            r_gain_d       <= '0;
            r_filter_ratio <= ONE_Q;
            r_drive_bias   <= '0;
            r_heat_mode    <= 1'b1;
            r_temp_ceiling <= '0;
            r_temp_floor   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAIN_P:       r_gain_p       <= i_cfg_data;
                CFG_GAIN_I:       r_gain_i       <= i_cfg_data;
                CFG_GAIN_D:       r_gain_d       <= i_cfg_data;
                CFG_FILTER_RATIO: r_filter_ratio <= i_cfg_data;
                CFG_DRIVE_BIAS:   r_drive_bias   <= i_cfg_data;
                CFG_HEAT_MODE:    r_heat_mode    <= i_cfg_data[0];
                CFG_TEMP_CEILING: r_temp_ceiling <= i_cfg_data;
                CFG_TEMP_FLOOR:   r_temp_floor   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pidfd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Shared multiplier with a registered product.
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        mul_en       = 1'b0;
        mul_a        = WIDE_W'(r_gain_p);
        mul_b        = err;
        div_start    = 1'b0;
        div_dividend = PROD_W'(r_gain_d) <<< 16;
        div_divisor  = (r_filter_ratio != '0) ? WIDE_W'(r_filter_ratio) : WIDE_W'(ONE_Q);
        o_in_stall   = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) n_state = ST_P_ERR;
            end
            ST_P_ERR: begin
                mul_en  = 1'b1;
                n_state = ST_KIKP;
            end
            ST_KIKP: begin
                mul_en  = 1'b1;
                mul_a   = WIDE_W'(r_gain_i);
                mul_b   = WIDE_W'(r_gain_p);
                n_state = ST_KPKD;
            end
            ST_KPKD: begin
                mul_en  = 1'b1;
                mul_a   = WIDE_W'(r_gain_p);
                mul_b   = WIDE_W'(r_gain_d);
                n_state = ST_KIH;
            end
            ST_KIH: begin
                mul_en  = 1'b1;
                mul_a   = WIDE_W'(r_kih);
                mul_b   = H_Q;
                n_state = ST_KIH_DONE;
            end
            ST_KIH_DONE: begin
                div_start = 1'b1;
                n_state   = ST_IK_MUL;
            end
            ST_IK_MUL: begin
                mul_en  = 1'b1;
                mul_a   = WIDE_W'(r_kih);
                mul_b   = perr;
                n_state = ST_IK;
            end
            ST_IK: begin
                n_state = ST_GAMMA_WAIT;
            end
            ST_GAMMA_WAIT: begin
                if (div_done) n_state = ST_GH;
            end
            ST_GH: begin
                mul_en  = 1'b1;
                mul_a   = WIDE_W'(r_gamma);
                mul_b   = WIDE_W'(r_deriv);
                n_state = (r_gh == '0) ? ST_SUM : ST_T1_DIV;
            end
            ST_T1_DIV: begin
                div_start    = 1'b1;
                div_dividend = r_prod;
                div_divisor  = r_gh;
                mul_en       = 1'b1;
                mul_a        = WIDE_W'(r_kpkd);
                mul_b        = dm;
                n_state      = ST_T1_WAIT;
            end
            ST_T1_WAIT: begin
                if (div_done) n_state = ST_T2_DIV;
            end
            ST_T2_DIV: begin
                div_start    = 1'b1;
                div_dividend = r_prod;
                div_divisor  = r_gh;
                n_state      = ST_T2_WAIT;
            end
            ST_T2_WAIT: begin
                if (div_done) n_state = ST_SUM;
            end
            ST_SUM: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Final sum, clamp, anti-windup and drive conversion.
    always_comb begin
        omax  = r_heat_mode ? OMAX_HOT : OMAX_COLD;
        omin  = r_heat_mode ? OMIN_HOT : OMIN_COLD;
        s_sum = (r_gain_p != '0) ?
            sat32(PROD_W'(r_ik) + PROD_W'(r_dk) + PROD_W'(r_pk) + PROD_W'(r_drive_bias)) :
            '0;
        if (s_sum > omax) begin
            s_clamp = omax;
        end else if (s_sum <= omin) begin
            s_clamp = omin;
        end else begin
            s_clamp = s_sum;
        end
        if (!r_heat_mode && r_ik <= omin) begin
            integ_next = omin;
        end else if (r_ms >= r_temp_ceiling && s_clamp == omax) begin
            integ_next = '0;
        end else if (r_heat_mode && r_ik > omax) begin
            integ_next = omax;
        end else if (r_ms <= r_temp_floor && s_clamp == omin) begin
            integ_next = '0;
        end else begin
            integ_next = r_ik;
        end
        s_final = r_heat_mode ? WIDE_W'(s_clamp) : -WIDE_W'(s_clamp);
        // Truncation toward zero leaves negatives at or below zero, which saturate to zero.
        if (s_final <= WIDE_W'(0)) begin
            drive_next = 8'd0;
        end else if (s_final[WIDE_W-2:16] > 16'd255) begin
            drive_next = 8'd255;
        end else begin
            drive_next = s_final[23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ms <= '0;
            r_last_sp <= '0;
            r_integ   <= '0;
            r_deriv   <= '0;
        end else if (r_state == ST_SUM && out_free) begin
            r_last_ms <= r_ms;
            r_last_sp <= r_sp;
            r_integ   <= integ_next;
            r_deriv   <= r_dk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_sp <= i_setpoint;
            r_ms <= i_measured;
        end
        case (r_state)
            ST_KIKP:       r_pk   <= prod_q;
            ST_KPKD:       r_kih  <= prod_q;
            ST_KIH:        r_kpkd <= prod_q;
            ST_KIH_DONE:   r_kih  <= prod_q;
            ST_IK:         r_ik   <= ik_next;
            ST_GAMMA_WAIT: begin
                if (div_done) begin
                    r_gamma <= div_q;
                    r_gh    <= gh_next;
                end
            end
            ST_GH:         r_dk   <= '0;
            ST_T1_WAIT:    if (div_done) r_t1 <= div_q;
            ST_T2_WAIT:    if (div_done) r_dk <= dk_next;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_SUM && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SUM && out_free) begin
            r_drive <= drive_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;

endmodule
